>>> src/position_velocity_kalman_filter_core_assert.svh
// Assertion macros used by the checker file.
`ifndef POSITION_VELOCITY_KALMAN_FILTER_CORE_ASSERT_SVH
`define POSITION_VELOCITY_KALMAN_FILTER_CORE_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define PVKF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a consequence holds in the cycle after the antecedent.
`define PVKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/pvkf_pkg.sv
`default_nettype none
package pvkf_pkg;
   localparam int WORD_BITS_DEF     = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int CSR_IDX_BITS      = 3;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [CSR_IDX_BITS-1:0] REG_TIME_STEP   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PROC_NOISE  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MEAS_NOISE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_POS   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_VEL   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_PVAR  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_VVAR  = 3'd6;

   localparam logic [1:0] MODE_BOTH    = 2'd0;
   localparam logic [1:0] MODE_INIT    = 2'd1;
   localparam logic [1:0] MODE_PREDICT = 2'd2;
   localparam logic [1:0] MODE_UPDATE  = 2'd3;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> src/position_velocity_kalman_filter_core.sv
`default_nettype none
// Position / velocity Kalman filter core (constant-velocity model, Q16.16).
// Requests arrive on req_valid/req_ready with mode, measurement and control.
// Mode 1 loads state from the CSRs, mode 2 predicts, mode 3 updates from the
// measurement and mode 0 predicts then updates. One response per request
// leaves on rsp_valid/rsp_ready with position, velocity, ready_res and
// divide_fault.
// A single shared multiply/divide unit does all products and quotients under
// a small microcoded sequencer. A predict or update request that arrives
// before initialization is answered without using the unit, and an update
// is skipped when the innovation variance is not positive. The filter
// accepts one request at a time and req_ready is low while it works or
// while a response is held; it rises the cycle after the response is taken.
// When the receiver stalls, the response stays in its output register and
// no new request is taken until it is delivered.
// Synchronous reset clears the estimates, covariance and derived terms and
// drops initialization; CSRs return to their default values.
module position_velocity_kalman_filter_core #(
   parameter int WORD_BITS     = pvkf_pkg::WORD_BITS_DEF,
   parameter int FRACTION_BITS = pvkf_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_mode,
   input  wire logic signed [31:0]                 req_measurement,
   input  wire logic signed [31:0]                 req_control,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [31:0]                      rsp_position,
   output logic signed [31:0]                      rsp_velocity,
   output logic                                    rsp_ready_res,
   output logic                                    rsp_divide_fault,
   input  wire logic                               csr_write_enable,
   input  wire logic [pvkf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [pvkf_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import pvkf_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // Register file of the working values, addressed by the microcode.
   localparam int NR = 16;
   localparam logic [3:0] R_X0 = 4'd0, R_X1 = 4'd1, R_P0 = 4'd2, R_P1 = 4'd3,
                          R_P2 = 4'd4, R_P3 = 4'd5, R_B0 = 4'd6, R_DT = 4'd7,
                          R_Q0 = 4'd8, R_Q1 = 4'd9, R_Q2 = 4'd10, R_U = 4'd11,
                          R_Z = 4'd12, R_T0 = 4'd13, R_T1 = 4'd14, R_T2 = 4'd15;

   logic [30:0]        time_step_ff, process_noise_ff, measure_noise_ff;
   logic [31:0]        start_position_ff, start_velocity_ff;
   logic [30:0]        start_pvar_ff, start_vvar_ff;

   logic signed [W-1:0] rf_ff [NR];
   logic signed [W-1:0] k0_ff, k1_ff, inn_ff;
   logic                init_ff;
   logic                fault_ff;
   logic [1:0]          mode_ff;
   logic [5:0]          pc_ff, pc_in;
   state_type           state_ff, state_in;
   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_pos_ff, rsp_vel_ff;
   logic                rsp_rr_ff, rsp_df_ff;

   // Sign-extend or saturate a 32-bit signed value into the word.
   function automatic logic signed [W-1:0] fit32(input logic signed [31:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (W >= 32) return W'(e);
      if (e > 64'(WMAX)) return WMAX;
      if (e < 64'(WMIN)) return WMIN;
      return W'(e);
   endfunction

   function automatic logic signed [W-1:0] fitu31(input logic [30:0] v);
      if (W > 31) return W'(v);
      if (64'(v) > 64'(WMAX)) return WMAX;
      return W'(v);
   endfunction

   function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (e > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (e < -64'sd2147483648) return 32'sh80000000;
      return e[31:0];
   endfunction

   // Microcode: each step issues op(a,b) on the shared unit, then writes
   // the post-processed result. Post kinds select how the result is combined.
   typedef enum logic [3:0] {
      PK_SET,      // dst = r
      PK_ADD,      // dst = dst + r
      PK_SUBD,     // dst = dst - r
      PK_K0, PK_K1, // latch gains
      PK_AUX       // unused, writes nothing
   } post_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] a;
      logic [3:0] b;
      logic       a_k;   // operand a comes from k0/k1 selected by a_k1
      logic       a_k1;
      logic       b_inn;
      post_type   post;
      logic [3:0] dst;
      logic       last;
   } uop_type;

   // Sequence start addresses.
   localparam logic [5:0] PC_INIT = 6'd0, PC_PRED = 6'd8, PC_UPD = 6'd20;

   uop_type uop;
   always_comb begin
      uop = '{op: OP_MUL, a: R_DT, b: R_DT, a_k: 1'b0, a_k1: 1'b0, b_inn: 1'b0,
              post: PK_SET, dst: R_T0, last: 1'b1};
      unique case (pc_ff)
         // init: T0=dt2, T1=dt3, T2=dt4, Q0=(dt4>>2)*q, Q1=(dt3>>1)*q, Q2=dt2*q
         6'd0: uop = '{OP_MUL, R_DT, R_DT, 1'b0, 1'b0, 1'b0, PK_SET, R_T0, 1'b0};
         6'd1: uop = '{OP_MUL, R_T0, R_DT, 1'b0, 1'b0, 1'b0, PK_SET, R_T1, 1'b0};
         6'd2: uop = '{OP_MUL, R_T1, R_DT, 1'b0, 1'b0, 1'b0, PK_SET, R_T2, 1'b0};
         6'd3: uop = '{OP_MUL, R_T2, R_Q0, 1'b0, 1'b0, 1'b0, PK_SET, R_Q0, 1'b0};
         6'd4: uop = '{OP_MUL, R_T1, R_Q1, 1'b0, 1'b0, 1'b0, PK_SET, R_Q1, 1'b0};
         6'd5: uop = '{OP_MUL, R_T0, R_Q2, 1'b0, 1'b0, 1'b0, PK_SET, R_Q2, 1'b1};
         // predict
         6'd8:  uop = '{OP_MUL, R_DT, R_P2, 1'b0, 1'b0, 1'b0, PK_ADD, R_P0, 1'b0};
         6'd9:  uop = '{OP_MUL, R_DT, R_P3, 1'b0, 1'b0, 1'b0, PK_ADD, R_P1, 1'b0};
         6'd10: uop = '{OP_MUL, R_DT, R_X1, 1'b0, 1'b0, 1'b0, PK_ADD, R_X0, 1'b0};
         6'd11: uop = '{OP_MUL, R_B0, R_U, 1'b0, 1'b0, 1'b0, PK_ADD, R_X0, 1'b0};
         6'd12: uop = '{OP_MUL, R_DT, R_U, 1'b0, 1'b0, 1'b0, PK_ADD, R_X1, 1'b0};
         6'd13: uop = '{OP_MUL, R_P1, R_DT, 1'b0, 1'b0, 1'b0, PK_ADD, R_P0, 1'b0};
         6'd14: uop = '{OP_MUL, R_P3, R_DT, 1'b0, 1'b0, 1'b0, PK_ADD, R_P2, 1'b1};
         // update
         6'd20: uop = '{OP_DIV, R_P0, R_T0, 1'b0, 1'b0, 1'b0, PK_K0, R_T0, 1'b0};
         6'd21: uop = '{OP_DIV, R_P2, R_T0, 1'b0, 1'b0, 1'b0, PK_K1, R_T0, 1'b0};
         6'd22: uop = '{OP_MUL, R_T0, R_T0, 1'b1, 1'b0, 1'b1, PK_ADD, R_X0, 1'b0};
         6'd23: uop = '{OP_MUL, R_T0, R_T0, 1'b1, 1'b1, 1'b1, PK_ADD, R_X1, 1'b0};
         6'd24: uop = '{OP_MUL, R_T0, R_P1, 1'b1, 1'b1, 1'b0, PK_SUBD, R_P3, 1'b0};
         6'd25: uop = '{OP_MUL, R_T0, R_P0, 1'b1, 1'b1, 1'b0, PK_SUBD, R_P2, 1'b0};
         6'd26: uop = '{OP_MUL, R_T0, R_P1, 1'b1, 1'b0, 1'b0, PK_SUBD, R_P1, 1'b0};
         6'd27: uop = '{OP_MUL, R_T0, R_P0, 1'b1, 1'b0, 1'b0, PK_SUBD, R_P0, 1'b1};
         default: ;
      endcase
   end

   // Innovation variance; P00 stays unchanged until the last update step, so
   // both divides can take it straight from the register file.
   logic signed [W-1:0] s_now;
   assign s_now = sadd(rf_ff[R_P0], fitu31(measure_noise_ff));

   // Operand formation, including the exact shifts of init.
   logic signed [W-1:0] opa, opb, alu_res;
   logic                alu_start, alu_done;
   always_comb begin
      opa = rf_ff[uop.a];
      if (uop.a_k) opa = uop.a_k1 ? k1_ff : k0_ff;
      if (pc_ff == 6'd3) opa = rf_ff[R_T2] >>> 2;
      if (pc_ff == 6'd4) opa = rf_ff[R_T1] >>> 1;
      opb = uop.b_inn ? inn_ff : rf_ff[uop.b];
      if (pc_ff == 6'd20 || pc_ff == 6'd21) opb = s_now;
   end

   pvkf_alu #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(uop.op),
      .op_a(opa), .op_b(opb), .done(alu_done), .result(alu_res)
   );

   logic accept_req;
   assign accept_req = req_valid && req_ready;

   // Sequencer: IDLE takes a request; ISSUE starts a unit op, or goes to DONE
   // for a skipped update; WAIT writes back; DONE loads the response register.
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      alu_start = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               if (req_mode == MODE_INIT) begin
                  pc_in = PC_INIT; state_in = ST_ISSUE;
               end else if (!init_ff) begin
                  state_in = ST_DONE;
               end else if (req_mode == MODE_UPDATE) begin
                  pc_in = PC_UPD; state_in = ST_ISSUE;
               end else begin
                  pc_in = PC_PRED; state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (pc_ff == PC_UPD && s_now <= 0) begin
               state_in = ST_DONE;
            end else begin
               alu_start = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (alu_done) begin
               if (!uop.last) begin
                  pc_in = pc_ff + 1'b1; state_in = ST_ISSUE;
               end else if (pc_ff == 6'd14 && mode_ff == MODE_BOTH) begin
                  pc_in = PC_UPD; state_in = ST_ISSUE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   // CSRs.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff      <= 31'd66;
         process_noise_ff  <= 31'd65536;
         measure_noise_ff  <= 31'd65536;
         start_position_ff <= '0;
         start_velocity_ff <= '0;
         start_pvar_ff     <= 31'd65536;
         start_vvar_ff     <= 31'd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_TIME_STEP:  time_step_ff      <= csr_write_data[30:0];
            REG_PROC_NOISE: process_noise_ff  <= csr_write_data[30:0];
            REG_MEAS_NOISE: measure_noise_ff  <= csr_write_data[30:0];
            REG_START_POS:  start_position_ff <= csr_write_data;
            REG_START_VEL:  start_velocity_ff <= csr_write_data;
            REG_START_PVAR: start_pvar_ff     <= csr_write_data[30:0];
            REG_START_VVAR: start_vvar_ff     <= csr_write_data[30:0];
            default: ;
         endcase
      end
   end

   // Datapath registers and write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NR; i++) rf_ff[i] <= '0;
         init_ff  <= 1'b0;
         fault_ff <= 1'b0;
      end else begin
         if (accept_req) begin
            mode_ff  <= req_mode;
            fault_ff <= 1'b0;
            rf_ff[R_U] <= fit32(req_control);
            rf_ff[R_Z] <= fit32(req_measurement);
            if (req_mode == MODE_INIT) begin
               rf_ff[R_DT] <= fitu31(time_step_ff);
               rf_ff[R_Q0] <= fitu31(process_noise_ff);
               rf_ff[R_Q1] <= fitu31(process_noise_ff);
               rf_ff[R_Q2] <= fitu31(process_noise_ff);
               rf_ff[R_X0] <= fit32(start_position_ff);
               rf_ff[R_X1] <= fit32(start_velocity_ff);
               rf_ff[R_P0] <= fitu31(start_pvar_ff);
               rf_ff[R_P1] <= '0;
               rf_ff[R_P2] <= '0;
               rf_ff[R_P3] <= fitu31(start_vvar_ff);
            end
         end
         if (state_ff == ST_ISSUE && pc_ff == PC_UPD) begin
            inn_ff <= ssub(rf_ff[R_Z], rf_ff[R_X0]);
            if (s_now <= 0) fault_ff <= 1'b1;
         end
         if (state_ff == ST_WAIT && alu_done) begin
            // The last predict step folds its product and all the process
            // noise terms into the covariance at once.
            if (pc_ff == 6'd14) begin
               rf_ff[R_P0] <= sadd(rf_ff[R_P0], rf_ff[R_Q0]);
               rf_ff[R_P1] <= sadd(rf_ff[R_P1], rf_ff[R_Q1]);
               rf_ff[R_P2] <= sadd(sadd(rf_ff[R_P2], alu_res), rf_ff[R_Q1]);
               rf_ff[R_P3] <= sadd(rf_ff[R_P3], rf_ff[R_Q2]);
            end else begin
               unique case (uop.post)
                  PK_SET:  rf_ff[uop.dst] <= alu_res;
                  PK_ADD:  rf_ff[uop.dst] <= sadd(rf_ff[uop.dst], alu_res);
                  PK_SUBD: rf_ff[uop.dst] <= ssub(rf_ff[uop.dst], alu_res);
                  PK_K0:   k0_ff <= alu_res;
                  PK_K1:   k1_ff <= alu_res;
                  default: ;
               endcase
            end
            // Fixed post-step of init that needs no product.
            if (pc_ff == 6'd5) begin
               rf_ff[R_B0] <= rf_ff[R_T0] >>> 1;
               init_ff <= 1'b1;
            end
         end
      end
      if (state_ff == ST_DONE) begin
         rsp_pos_ff <= init_ff ? out32(rf_ff[R_X0]) : out32(rf_ff[R_Z]);
         rsp_vel_ff <= init_ff ? out32(rf_ff[R_X1]) : '0;
         rsp_rr_ff  <= init_ff;
         rsp_df_ff  <= fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_ready_res    = rsp_rr_ff;
   assign rsp_divide_fault = rsp_df_ff;
endmodule
`default_nettype wire

>>> src/pvkf_alu.sv
`default_nettype none
// Shared saturating fixed-point multiply / divide unit. Multiply uses one
// half-word partial product per cycle; divide produces one quotient bit per cycle.
module pvkf_alu #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire pvkf_pkg::op_type            op,
   input  wire logic signed [WORD_BITS-1:0] op_a,
   input  wire logic signed [WORD_BITS-1:0] op_b,
   output logic                             done,
   output logic signed [WORD_BITS-1:0]      result
);
   import pvkf_pkg::*;

   localparam int HB    = (WORD_BITS + 1) / 2;
   localparam int PW    = 2 * WORD_BITS;
   localparam int NB    = WORD_BITS + FRACTION_BITS;
   localparam int CW    = $clog2(NB + 1);
   localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic               busy_ff, busy_in;
   op_type             op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [WORD_BITS-1:0] ua_ff, ua_in, ub_ff, ub_in;
   logic [PW-1:0]      acc_ff, acc_in;
   logic [WORD_BITS:0] rem_ff, rem_in;
   logic [NB-1:0]      num_ff, num_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic signed [WORD_BITS-1:0] res_ff, res_in;

   logic [WORD_BITS-1:0] mag_a, mag_b;
   logic [HB-1:0]        pa, pb;
   logic [2*HB-1:0]      pp;
   logic [PW-1:0]        pp_sh, shifted;
   logic [WORD_BITS:0]   rem_try;
   logic                 big;

   assign mag_a = op_a[WORD_BITS-1] ? WORD_BITS'(-op_a) : op_a;
   assign mag_b = op_b[WORD_BITS-1] ? WORD_BITS'(-op_b) : op_b;

   // Partial product select: cnt 0..3 walks (lo,lo),(lo,hi),(hi,lo),(hi,hi).
   always_comb begin
      pa = cnt_ff[1] ? HB'(ua_ff >> HB) : HB'(ua_ff);
      pb = cnt_ff[0] ? HB'(ub_ff >> HB) : HB'(ub_ff);
      pp = pa * pb;
      pp_sh = PW'(pp) << (HB * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
      shifted = acc_ff >> FRACTION_BITS;
      rem_try = {rem_ff[WORD_BITS-1:0], num_ff[NB-1]};
      big = (shifted >> (WORD_BITS - 1)) != '0;
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         cnt_in  = '0;
         acc_in  = '0;
         rem_in  = '0;
         ua_in   = mag_a;
         ub_in   = (op == OP_DIV) ? op_b : mag_b;
         neg_in  = (op == OP_DIV) ? op_a[WORD_BITS-1]
                                  : (op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1]);
         num_in  = NB'(mag_a) << FRACTION_BITS;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            if (cnt_ff == CW'(4)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if (big) res_in = neg_ff ? WMIN : WMAX;
               else res_in = neg_ff ? WORD_BITS'(-shifted[WORD_BITS-1:0])
                                    : shifted[WORD_BITS-1:0];
            end else begin
               acc_in = acc_ff + pp_sh;
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            if (cnt_ff == CW'(NB)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if ((acc_ff >> (WORD_BITS - 1)) != '0) res_in = neg_ff ? WMIN : WMAX;
               else res_in = neg_ff ? WORD_BITS'(-acc_ff[WORD_BITS-1:0])
                                    : acc_ff[WORD_BITS-1:0];
            end else begin
               num_in = num_ff << 1;
               cnt_in = cnt_ff + 1'b1;
               if (rem_try >= {1'b0, ub_ff}) begin
                  rem_in = rem_try - {1'b0, ub_ff};
                  acc_in = {acc_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rem_try;
                  acc_in = {acc_ff[PW-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

>>> src/pvkf_checker.sv
`default_nettype none
`include "position_velocity_kalman_filter_core_assert.svh"
// Port-level checks of the filter core.
module pvkf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_ready_res,
   input wire logic rsp_divide_fault
);
   `PVKF_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `PVKF_ASSERT_IMPL(a_no_take_while_held, clock, reset, rsp_valid, !req_ready)
   `PVKF_ASSERT_IMPL(a_fault_needs_init, clock, reset, rsp_valid && rsp_divide_fault, rsp_ready_res)
   `PVKF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ready_res))
endmodule

bind position_velocity_kalman_filter_core pvkf_checker u_pvkf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ready_res(rsp_ready_res),
   .rsp_divide_fault(rsp_divide_fault)
);
`default_nettype wire
